>>> hdl/grbk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grbk_pkg: shared types and constants for the record grouping block
// Table sizes, field widths, request/result payloads and control commands.
// ----------------------------------------------------------------------------
package grbk_pkg;

	localparam int MAX_SENSORS    = 16;
	localparam int MAX_PER_SENSOR = 256;
	localparam int RECORD_WIDTH   = 64;

	// fixed field widths of the request and result payloads
	localparam int ID_W     = 16;
	localparam int REC_W    = 64;
	localparam int BUCKET_W = 4;
	localparam int POS_W    = 8;
	localparam int COUNT_W  = 5;

	// internal widths derived from the table sizes
	localparam int SENS_IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int SLOT_W     = (MAX_PER_SENSOR > 1) ? $clog2(MAX_PER_SENSOR) : 1;
	localparam int FILL_W     = $clog2(MAX_PER_SENSOR + 1);
	localparam int TOTAL_W    = $clog2(MAX_SENSORS + 1);
	localparam int ADDR_W     = SENS_IDX_W + SLOT_W;
	localparam int STORE_DEPTH = 1 << ADDR_W;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [ID_W-1:0]     sensor_id;
		logic [REC_W-1:0]    record;
		logic [BUCKET_W-1:0] read_bucket;
		logic [POS_W-1:0]    read_position;
		logic                last_line;
	} in_item_t;

	typedef struct packed {
		logic [BUCKET_W-1:0] bucket;
		logic [POS_W-1:0]    position;
		logic                new_sensor;
		logic                overflow;
		logic [COUNT_W-1:0]  sensor_count;
		logic [REC_W-1:0]    read_record;
		logic                read_valid;
		logic                done_res;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the accepted request
		logic exec;      // lookup, table update, store access
		logic load_out;  // load the result register
	} ctrl_cmd_t;

endpackage

>>> hdl/grbk_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grbk_in_if: request channel
// Valid/ready channel carrying one insert or read request.
// ----------------------------------------------------------------------------
interface grbk_in_if;
	logic               valid;
	logic               ready;
	grbk_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/grbk_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grbk_out_if: result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface grbk_out_if;
	logic                valid;
	logic                ready;
	grbk_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/grbk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grbk_ctrl: sequencing controller
// Capture, execute and finish phases; owns the handshakes and result valid.
// ----------------------------------------------------------------------------
module grbk_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output grbk_pkg::ctrl_cmd_t cmd
);
	import grbk_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_load;

	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	// a new request may enter in the cycle the previous result is parked
	assign in_ready  = (state_q == ST_IDLE) || out_load;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.capture  = in_valid && in_ready;
		cmd.exec     = (state_q == ST_LOOK);
		cmd.load_out = out_load;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_LOOK;
			end
			ST_LOOK: begin
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (out_load) state_nxt = in_valid ? ST_LOOK : ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_capture_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_LOOK))
		else $error("accepted request did not enter execute");
	a_look_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |=> (state_q == ST_FIN))
		else $error("execute not followed by finish");
	a_no_accept_in_look: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> !in_ready)
		else $error("request accepted during execute");
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("loaded result not presented");
`endif

endmodule

>>> hdl/grbk_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grbk_datapath: key table, fill counters, record store and result register
// Parallel key match over the open buckets, single-port record memory.
// ----------------------------------------------------------------------------
module grbk_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  grbk_pkg::ctrl_cmd_t cmd,
	input  grbk_pkg::in_item_t  in_data,
	output grbk_pkg::out_item_t out_data
);
	import grbk_pkg::*;

	in_item_t req_q;

	logic [ID_W-1:0]    keys_q [MAX_SENSORS];
	logic [FILL_W-1:0]  fill_q [MAX_SENSORS];
	logic [TOTAL_W-1:0] total_q;

	logic [RECORD_WIDTH-1:0] store [STORE_DEPTH];
	logic [RECORD_WIDTH-1:0] rdata_q;

	logic [BUCKET_W-1:0] res_bkt_q;
	logic [POS_W-1:0]    res_pos_q;
	logic                res_fresh_q;
	logic                res_ovf_q;
	logic                res_rvalid_q;
	logic                res_last_q;

	out_item_t out_q;

	// lookup
	logic [MAX_SENSORS-1:0] hit;
	logic                   found;
	logic [SENS_IDX_W-1:0]  hit_idx;
	logic [SENS_IDX_W-1:0]  k_idx;
	logic                   tbl_full, tbl_ovf, open_new, bkt_ovf, ins_ovf;
	logic [FILL_W-1:0]      sel_fill;
	logic [SENS_IDX_W-1:0]  rd_idx;
	logic                   rd_ok;
	logic                   is_insert;
	logic [ADDR_W-1:0]      wr_addr, rd_addr;

	always_comb begin
		for (int k = 0; k < MAX_SENSORS; k++) begin
			hit[k] = (TOTAL_W'(k) < total_q) && (keys_q[k] == req_q.sensor_id);
		end
		hit_idx = '0;
		for (int k = MAX_SENSORS - 1; k >= 0; k--) begin
			if (hit[k]) hit_idx = SENS_IDX_W'(k);
		end
	end

	assign is_insert = (req_q.cmd == CMD_INSERT);
	assign found     = |hit;
	assign tbl_full  = (total_q >= TOTAL_W'(MAX_SENSORS));
	assign tbl_ovf   = !found && tbl_full;
	assign open_new  = !found && !tbl_full;
	assign k_idx     = found ? hit_idx : SENS_IDX_W'(total_q);
	assign sel_fill  = open_new ? '0 : fill_q[k_idx];
	assign bkt_ovf   = !tbl_ovf && (sel_fill >= FILL_W'(MAX_PER_SENSOR));
	assign ins_ovf   = tbl_ovf || bkt_ovf;
	assign wr_addr   = {k_idx, sel_fill[SLOT_W-1:0]};

	assign rd_idx  = SENS_IDX_W'(req_q.read_bucket);
	assign rd_ok   = (TOTAL_W'(req_q.read_bucket) < total_q)
		&& (TOTAL_W'(req_q.read_bucket) < TOTAL_W'(MAX_SENSORS))
		&& (FILL_W'(req_q.read_position) < fill_q[rd_idx])
		&& (FILL_W'(req_q.read_position) < FILL_W'(MAX_PER_SENSOR));
	assign rd_addr = {rd_idx, SLOT_W'(req_q.read_position)};

	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= in_data;
	end

	// key table: written only when a bucket opens, never read beyond total_q
	always_ff @(posedge clk) begin
		if (cmd.exec && is_insert && open_new) keys_q[k_idx] <= req_q.sensor_id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			for (int k = 0; k < MAX_SENSORS; k++) fill_q[k] <= '0;
		end else if (cmd.exec && is_insert) begin
			if (open_new) total_q <= total_q + 1'b1;
			if (!ins_ovf) fill_q[k_idx] <= sel_fill + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && is_insert && !ins_ovf) store[wr_addr] <= req_q.record[RECORD_WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && !is_insert) rdata_q <= store[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_last_q <= req_q.last_line;
			if (is_insert) begin
				res_bkt_q    <= tbl_ovf ? '0 : BUCKET_W'(k_idx);
				res_pos_q    <= ins_ovf ? '0 : POS_W'(sel_fill);
				res_fresh_q  <= open_new;
				res_ovf_q    <= ins_ovf;
				res_rvalid_q <= 1'b0;
			end else begin
				res_bkt_q    <= req_q.read_bucket;
				res_pos_q    <= req_q.read_position;
				res_fresh_q  <= 1'b0;
				res_ovf_q    <= 1'b0;
				res_rvalid_q <= rd_ok;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.bucket       <= res_bkt_q;
			out_q.position     <= res_pos_q;
			out_q.new_sensor   <= res_fresh_q;
			out_q.overflow     <= res_ovf_q;
			out_q.sensor_count <= COUNT_W'(total_q);
			out_q.read_record  <= res_rvalid_q ? REC_W'(rdata_q) : '0;
			out_q.read_valid   <= res_rvalid_q;
			out_q.done_res     <= res_last_q;
		end
	end

	assign out_data = out_q;

`ifndef SYNTHESIS
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOTAL_W'(MAX_SENSORS))
		else $error("sensor total beyond table size");
	a_open_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && is_insert && open_new) |=> (total_q == $past(total_q) + 1'b1))
		else $error("bucket opened without count update");
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> $onehot0(hit))
		else $error("sensor id held by more than one bucket");
`endif

endmodule

>>> hdl/group_records_by_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_records_by_key: groups measurement records into buckets by sensor id
// Top level; joins the controller and datapath to the two channels.
// ----------------------------------------------------------------------------
// Usage:
//   items   - request channel. cmd insert: sensor_id is looked up among the
//             open buckets, a new bucket is opened for an unknown id, and the
//             record is appended at the bucket's next slot. cmd read: the
//             record at read_bucket/read_position is returned if that slot
//             has been filled. last_line is echoed as done_res.
//   results - one result per request: bucket, position, new_sensor,
//             overflow (record dropped, sensor table or bucket full),
//             sensor_count after the request, read_record and read_valid.
//   A request is captured, then the execute phase matches the key, updates
//   the fill count and accesses the single-port record memory, and the
//   finish phase loads the result register. The next request may be
//   accepted as that result is loaded, but never during execute.
//   Reset empties the key table and all fill counts at once; no clearing
//   pass is run. While the receiver stalls one result is held and the next
//   request is accepted and executed; it then waits until the held result
//   is taken.
// ----------------------------------------------------------------------------
module group_records_by_key (
	input  logic clk,
	input  logic arst_n,
	grbk_in_if.sink    items,
	grbk_out_if.source results
);
	import grbk_pkg::*;

	ctrl_cmd_t cmd;
	logic      in_ready;
	logic      out_valid;

	grbk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (results.ready),
		.cmd       (cmd)
	);

	grbk_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (items.data),
		.out_data (results.data)
	);

	assign items.ready   = in_ready;
	assign results.valid = out_valid;

endmodule
